// ----- rtl/core/button_press_counter_with_blink_core_assert.svh -----
// assertion macros for the button press counter core
`ifndef BUTTON_PRESS_COUNTER_WITH_BLINK_CORE_ASSERT_SVH
`define BUTTON_PRESS_COUNTER_WITH_BLINK_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BPCB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPCB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BPCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/bpcb_pkg.sv -----
// types and constants shared by the button press counter core
`timescale 1ns / 1ps
package bpcb_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_ON      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_OFF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WINDOW = 3'd5;

    // session modes
    localparam logic [1:0] MODE_WAIT  = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;

    // session phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_RUN     = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    localparam logic [7:0]  HOLD_MIN_RST    = 8'd20;
    localparam logic [15:0] IDLE_WINDOW_RST = 16'd500;
    localparam logic [7:0]  SAT_MAX         = 8'hFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] led_on_ms;
        logic [15:0] led_off_ms;
        logic [15:0] duration_ms;
        logic [7:0]  hold_min_ms;
        logic [15:0] idle_window_ms;
    } t_cfg;

    typedef struct packed {
        logic       led_lit;
        logic       busy_res;
        logic       done_res;
        logic [7:0] press_count;
        logic       any_press;
    } t_res;

endpackage

// ----- rtl/core/bpcb_if.sv -----
// handshake channel interfaces for ticks, results and register writes
`timescale 1ns / 1ps
interface bpcb_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic btn_down;

    modport source (output valid, output start_req, output btn_down, input ready);
    modport sink   (input valid, input start_req, input btn_down, output ready);
endinterface

interface bpcb_out_if;
    logic       valid;
    logic       ready;
    logic       led_lit;
    logic       busy_res;
    logic       done_res;
    logic [7:0] press_count;
    logic       any_press;

    modport source (output valid, output led_lit, output busy_res, output done_res,
                    output press_count, output any_press, input ready);
    modport sink   (input valid, input led_lit, input busy_res, input done_res,
                    input press_count, input any_press, output ready);
endinterface

interface bpcb_cfg_if;
    import bpcb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bpcb_cfg_regs.sv -----
// configuration register file
`timescale 1ns / 1ps
module bpcb_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpcb_cfg_if.sink      i_cfg,
    output bpcb_pkg::t_cfg o_cfg
);
    import bpcb_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_WAIT;
            r_cfg.led_on_ms      <= '0;
            r_cfg.led_off_ms     <= '0;
            r_cfg.duration_ms    <= '0;
            r_cfg.hold_min_ms    <= HOLD_MIN_RST;
            r_cfg.idle_window_ms <= IDLE_WINDOW_RST;
        end else if (w_wr) begin
            case (i_cfg.index)
                CFG_MODE:        r_cfg.mode           <= i_cfg.data[1:0];
                CFG_LED_ON:      r_cfg.led_on_ms      <= i_cfg.data;
                CFG_LED_OFF:     r_cfg.led_off_ms     <= i_cfg.data;
                CFG_DURATION:    r_cfg.duration_ms    <= i_cfg.data;
                CFG_HOLD_MIN:    r_cfg.hold_min_ms    <= i_cfg.data[7:0];
                CFG_IDLE_WINDOW: r_cfg.idle_window_ms <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/bpcb_session.sv -----
// session state and per-tick update: blink, hold timing, press count
`timescale 1ns / 1ps
module bpcb_session (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_start,
    input  logic           i_btn,
    input  bpcb_pkg::t_cfg i_cfg,
    output bpcb_pkg::t_res o_res
);
    import bpcb_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic        r_led, n_led;
    logic [7:0]  r_hold, n_hold;
    logic [7:0]  r_pres, n_pres;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_idle, n_idle;

    always_comb begin
        logic        m_wait;
        logic        m_count;
        logic        m_fixed;
        logic        go;
        logic        blink_en;
        logic [15:0] cycle_len;
        logic        done;
        logic [7:0]  count;

        m_wait    = (i_cfg.mode == MODE_WAIT);
        m_count   = (i_cfg.mode == MODE_COUNT);
        m_fixed   = !m_wait && !m_count;
        cycle_len = i_cfg.led_on_ms + i_cfg.led_off_ms;
        done      = 1'b0;
        count     = '0;
        go        = 1'b0;
        blink_en  = 1'b0;

        n_phase = r_phase;
        n_pos   = r_pos;
        n_led   = r_led;
        n_hold  = r_hold;
        n_pres  = r_pres;
        n_rem   = r_rem;
        n_idle  = r_idle;

        if (i_start) begin
            n_phase = PH_RUN;
            n_pos   = 16'd1;
            n_led   = 1'b0;
            n_hold  = '0;
            n_pres  = '0;
            n_rem   = i_cfg.duration_ms;
            n_idle  = '0;
        end

        if (n_phase == PH_RUN) begin
            if (m_wait) begin
                go = (n_rem != '0) && (n_pres == '0);
            end else if (m_count) begin
                go = (n_pres == '0) || (n_idle != '0);
            end else begin
                go = (n_rem != '0);
            end

            if (go) begin
                blink_en = !m_fixed || (i_cfg.led_on_ms != '0);
                if (blink_en) begin
                    if (n_pos == 16'd1) begin
                        n_led = 1'b1;
                    end else if (n_pos == i_cfg.led_on_ms) begin
                        n_led = 1'b0;
                    end else if (n_pos == cycle_len) begin
                        n_pos = '0;
                    end
                end
                n_pos = n_pos + 16'd1;

                if (i_btn) begin
                    if (n_hold != SAT_MAX) begin
                        n_hold = n_hold + 8'd1;
                    end
                end else begin
                    if (n_hold > i_cfg.hold_min_ms && n_pres != SAT_MAX) begin
                        n_pres = n_pres + 8'd1;
                    end
                    n_hold = '0;
                end

                if (m_count) begin
                    if (n_hold != '0) begin
                        n_idle = i_cfg.idle_window_ms;
                    end
                    if (n_idle != '0) begin
                        n_idle = n_idle - 16'd1;
                    end
                end else begin
                    n_rem = n_rem - 16'd1;
                end
            end else begin
                n_led = 1'b0;
                // short fixed delay skips the release wait
                if (m_fixed && i_cfg.duration_ms <= {8'd0, i_cfg.hold_min_ms}) begin
                    count   = {7'd0, (n_hold != '0)};
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_RELEASE;
                end
            end
        end

        if (n_phase == PH_RELEASE && !i_btn) begin
            count = n_pres;
            if (n_hold > i_cfg.hold_min_ms && count != SAT_MAX) begin
                count = count + 8'd1;
            end
            done    = 1'b1;
            n_phase = PH_IDLE;
        end

        o_res.led_lit     = n_led;
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.press_count = done ? count : 8'd0;
        o_res.any_press   = done && (count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 16'd1;
            r_led   <= 1'b0;
            r_hold  <= '0;
            r_pres  <= '0;
            r_rem   <= '0;
            r_idle  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_led   <= n_led;
            r_hold  <= n_hold;
            r_pres  <= n_pres;
            r_rem   <= n_rem;
            r_idle  <= n_idle;
        end
    end

endmodule

// ----- rtl/core/button_press_counter_with_blink_core.sv -----
// button press counter with blink: top level with tick and result registers
// throughput: one tick per cycle while o_out.ready stays high
// a tick is held in the input register and updated into the result register
// synchronous active-low reset clears session state and both valid flags
// registers reset to mode 0, hold minimum 20 and idle window 500
`timescale 1ns / 1ps
module button_press_counter_with_blink_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpcb_in_if.sink    i_in,
    bpcb_out_if.source o_out,
    bpcb_cfg_if.sink   i_cfg
);
    import bpcb_pkg::*;

`include "button_press_counter_with_blink_core_assert.svh"

    t_cfg w_cfg;
    t_res w_res;
    t_res r_out;
    logic r_out_valid;
    logic r_in_valid;
    logic r_in_start;
    logic r_in_btn;
    logic w_step;
    logic w_in_take;

    bpcb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    bpcb_session u_session (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_start (r_in_start),
        .i_btn   (r_in_btn),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // a held tick moves on whenever the result slot is free or being drained
    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_start <= i_in.start_req;
            r_in_btn   <= i_in.btn_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.led_lit     = r_out.led_lit;
    assign o_out.busy_res    = r_out.busy_res;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.press_count = r_out.press_count;
    assign o_out.any_press   = r_out.any_press;

    `BPCB_ASSERT_NEXT(a_step_loads_result, i_clk, i_rst_n, w_step, r_out_valid)
    `BPCB_ASSERT_NEXT(a_in_holds_on_stall, i_clk, i_rst_n, r_in_valid && !w_step, r_in_valid && $stable(r_in_start) && $stable(r_in_btn))
    `BPCB_ASSERT_SAME(a_no_count_without_done, i_clk, i_rst_n, r_out_valid && !r_out.done_res, r_out.press_count == 8'd0 && !r_out.any_press)
    `BPCB_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res && (r_out.any_press == (r_out.press_count != 8'd0)))

endmodule
